// ===== rtl/mlsb_pkg.sv =====
// ----------------------------------------------------------------------------
// mlsb_pkg: shared types and helpers for the MMIO load/store bus bridge
// Holds the phase encoding, the per-tick result bundle, the register
// indexes, the reset addresses and the size, strobe and extension helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mlsb_pkg;

  localparam int unsigned TAG_FIELD_W       = 16;
  localparam int unsigned TAG_WIDTH_DEFAULT = 16;

  localparam logic [31:0] TIMER_LOW_RESET  = 32'h0200_BFF8;
  localparam logic [31:0] TIMER_HIGH_RESET = 32'h0200_BFFC;

  // Configuration register indexes
  localparam logic [0:0] CFG_TIMER_LOW  = 1'b0;
  localparam logic [0:0] CFG_TIMER_HIGH = 1'b1;

  // Load funct3 codes that need extension work
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  // Access width codes (low two funct3 bits)
  localparam logic [1:0] WID_BYTE = 2'd0;
  localparam logic [1:0] WID_HALF = 2'd1;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd3;

  localparam logic [3:0] STRB_BYTE = 4'h1;
  localparam logic [3:0] STRB_HALF = 4'h3;
  localparam logic [3:0] STRB_WORD = 4'hF;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ISSUE,
    PH_WAIT
  } phase_t;

  typedef struct packed {
    logic                   core_ready;
    logic                   core_resp_valid;
    logic [31:0]            core_resp_data;
    logic [TAG_FIELD_W-1:0] core_resp_tag;
    logic                   core_resp_skip_check;
    logic                   bus_req_valid;
    logic                   bus_req_is_write;
    logic [31:0]            bus_req_address;
    logic [1:0]             bus_req_size;
    logic [3:0]             bus_req_strobe;
    logic [31:0]            bus_req_write_data;
    logic                   bus_resp_ready;
  } res_t;

  function automatic logic [1:0] size_code(input logic [2:0] f3);
    case (f3[1:0])
      WID_BYTE: return SIZE_BYTE;
      WID_HALF: return SIZE_HALF;
      default:  return SIZE_WORD;
    endcase
  endfunction

  function automatic logic [3:0] strobe_of(input logic [2:0] f3);
    case (f3[1:0])
      WID_BYTE: return STRB_BYTE;
      WID_HALF: return STRB_HALF;
      default:  return STRB_WORD;
    endcase
  endfunction

  function automatic logic [31:0] masked_store(input logic [31:0] d, input logic [2:0] f3);
    case (f3[1:0])
      WID_BYTE: return {24'd0, d[7:0]};
      WID_HALF: return {16'd0, d[15:0]};
      default:  return d;
    endcase
  endfunction

  function automatic logic [31:0] extend_load(input logic [31:0] w, input logic [2:0] f3);
    case (f3)
      F3_LB:   return {{24{w[7]}}, w[7:0]};
      F3_LH:   return {{16{w[15]}}, w[15:0]};
      F3_LBU:  return {24'd0, w[7:0]};
      F3_LHU:  return {16'd0, w[15:0]};
      default: return w;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mlsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlsb_ctrl: bridge state and per-tick result
// Builds the result of one tick from the held state and advances the state
// from the tick's inputs when step is high. Holds the timer address registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mlsb_ctrl
  import mlsb_pkg::*;
#(
  parameter int unsigned TAG_WIDTH = TAG_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [0:0]             cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic                   step,
  input  wire logic                   core_req_valid,
  input  wire logic                   core_req_write,
  input  wire logic [31:0]            core_req_address,
  input  wire logic [31:0]            core_req_store_data,
  input  wire logic [2:0]             core_req_funct3,
  input  wire logic [TAG_FIELD_W-1:0] core_req_tag,
  input  wire logic [63:0]            timer_value,
  input  wire logic                   bus_write_accepted,
  input  wire logic                   bus_write_done,
  input  wire logic                   bus_read_accepted,
  input  wire logic                   bus_read_done,
  input  wire logic [31:0]            bus_read_data,
  output res_t                        res
);

  localparam int unsigned HeldTagW = (TAG_WIDTH < TAG_FIELD_W) ? TAG_WIDTH : TAG_FIELD_W;

  logic [31:0] timer_low_address;
  logic [31:0] timer_high_address;

  phase_t              phase, phase_next;
  logic                pending_is_write, pending_is_write_next;
  logic                response_pending, response_pending_next;
  logic [31:0]         held_address, held_address_next;
  logic [31:0]         held_store_data, held_store_data_next;
  logic [2:0]          held_funct3, held_funct3_next;
  logic [31:0]         held_read_result, held_read_result_next;
  logic [HeldTagW-1:0] held_tag, held_tag_next;
  logic                held_skip_check, held_skip_check_next;

  logic hit_low;
  logic hit_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_low_address  <= TIMER_LOW_RESET;
      timer_high_address <= TIMER_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TIMER_LOW:  timer_low_address  <= cfg_data;
        CFG_TIMER_HIGH: timer_high_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      pending_is_write <= 1'b0;
      response_pending <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      pending_is_write <= pending_is_write_next;
      response_pending <= response_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held_address     <= held_address_next;
      held_store_data  <= held_store_data_next;
      held_funct3      <= held_funct3_next;
      held_read_result <= held_read_result_next;
      held_tag         <= held_tag_next;
      held_skip_check  <= held_skip_check_next;
    end
  end

  assign hit_low  = (core_req_address == timer_low_address);
  assign hit_high = (core_req_address == timer_high_address);

  // Result of this tick: a function of held state only
  always_comb begin
    res = '0;
    res.core_ready = (phase == PH_IDLE);
    if (response_pending) begin
      res.core_resp_valid      = 1'b1;
      res.core_resp_data       = held_read_result;
      res.core_resp_tag        = TAG_FIELD_W'(held_tag);
      res.core_resp_skip_check = held_skip_check;
    end
    if (phase != PH_IDLE) begin
      res.bus_req_is_write = pending_is_write;
    end
    if (phase == PH_ISSUE) begin
      res.bus_req_valid   = 1'b1;
      res.bus_req_address = held_address;
      res.bus_req_size    = size_code(held_funct3);
      if (pending_is_write) begin
        res.bus_req_strobe     = strobe_of(held_funct3);
        res.bus_req_write_data = masked_store(held_store_data, held_funct3);
      end
    end
    if (phase == PH_WAIT) begin
      res.bus_resp_ready = 1'b1;
    end
  end

  always_comb begin
    phase_next            = phase;
    pending_is_write_next = pending_is_write;
    response_pending_next = 1'b0;
    held_address_next     = held_address;
    held_store_data_next  = held_store_data;
    held_funct3_next      = held_funct3;
    held_read_result_next = held_read_result;
    held_tag_next         = held_tag;
    held_skip_check_next  = held_skip_check;
    unique case (phase)
      PH_IDLE: begin
        if (core_req_valid) begin
          held_address_next = core_req_address;
          held_tag_next     = core_req_tag[HeldTagW-1:0];
          if (!core_req_write && (hit_low || hit_high)) begin
            // answer locally; low half wins when both addresses match
            pending_is_write_next = 1'b0;
            response_pending_next = 1'b1;
            held_store_data_next  = '0;
            held_funct3_next      = '0;
            held_read_result_next = hit_low ? timer_value[31:0] : timer_value[63:32];
            held_skip_check_next  = 1'b1;
          end else begin
            phase_next            = PH_ISSUE;
            pending_is_write_next = core_req_write;
            held_store_data_next  = core_req_store_data;
            held_funct3_next      = core_req_funct3;
            held_read_result_next = '0;
            held_skip_check_next  = 1'b0;
          end
        end
      end
      PH_ISSUE: begin
        if (pending_is_write ? bus_write_accepted : bus_read_accepted) begin
          phase_next = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (pending_is_write) begin
          if (bus_write_done) begin
            phase_next            = PH_IDLE;
            pending_is_write_next = 1'b0;
            response_pending_next = 1'b1;
            held_read_result_next = '0;
          end
        end else if (bus_read_done) begin
          phase_next            = PH_IDLE;
          response_pending_next = 1'b1;
          held_read_result_next = extend_load(bus_read_data, held_funct3);
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  a_resp_only_idle: assert property (@(posedge clk) disable iff (rst)
    response_pending |-> (phase == PH_IDLE))
    else $error("response held while a bus access is still open");

  a_issue_not_dropped: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_ISSUE) |=> (phase != PH_IDLE))
    else $error("bus request dropped before acceptance");

  a_write_done_resp: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_WAIT && pending_is_write && bus_write_done)
      |=> (response_pending && !held_skip_check))
    else $error("write completion gave no response");

endmodule

`default_nettype wire

// ===== rtl/mmio_load_store_bus_bridge.sv =====
// ----------------------------------------------------------------------------
// mmio_load_store_bus_bridge: core MMIO requests to a lite memory-mapped bus
// One input item is one tick of the bridge: the core request, the bus
// handshake flags, the read word and the 64-bit timer. One result item comes
// back per input item with core ready, the response and the bus request.
//
// Usage: present an item with in_valid; it is taken when in_ready is high.
// Its result appears on out_valid in the cycle after acceptance and stays until
// out_ready. in_ready is high while the output register is empty or being
// taken in the same cycle, so one item per cycle is sustained while out_ready
// stays high, set by the single output register after the state update logic.
// Loads of the two timer addresses are answered in the result of the next
// tick, marked skip-check; other requests run the bus request and response
// phases over later ticks. A stalled receiver stops intake; nothing is lost.
// Reset clears the bridge to idle with no response pending and loads the
// default timer addresses. cfg_write writes register cfg_index at once;
// write only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module mmio_load_store_bus_bridge
  import mlsb_pkg::*;
#(
  parameter int unsigned TAG_WIDTH = TAG_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [0:0]             cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   core_req_valid,
  input  wire logic                   core_req_write,
  input  wire logic [31:0]            core_req_address,
  input  wire logic [31:0]            core_req_store_data,
  input  wire logic [2:0]             core_req_funct3,
  input  wire logic [TAG_FIELD_W-1:0] core_req_tag,
  input  wire logic [63:0]            timer_value,
  input  wire logic                   bus_write_accepted,
  input  wire logic                   bus_write_done,
  input  wire logic                   bus_read_accepted,
  input  wire logic                   bus_read_done,
  input  wire logic [31:0]            bus_read_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        core_ready,
  output logic                        core_resp_valid,
  output logic [31:0]                 core_resp_data,
  output logic [TAG_FIELD_W-1:0]      core_resp_tag,
  output logic                        core_resp_skip_check,
  output logic                        bus_req_valid,
  output logic                        bus_req_is_write,
  output logic [31:0]                 bus_req_address,
  output logic [1:0]                  bus_req_size,
  output logic [3:0]                  bus_req_strobe,
  output logic [31:0]                 bus_req_write_data,
  output logic                        bus_resp_ready
);

  logic step;
  res_t res;
  res_t out_res;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  mlsb_ctrl #(
    .TAG_WIDTH(TAG_WIDTH)
  ) u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .step               (step),
    .core_req_valid     (core_req_valid),
    .core_req_write     (core_req_write),
    .core_req_address   (core_req_address),
    .core_req_store_data(core_req_store_data),
    .core_req_funct3    (core_req_funct3),
    .core_req_tag       (core_req_tag),
    .timer_value        (timer_value),
    .bus_write_accepted (bus_write_accepted),
    .bus_write_done     (bus_write_done),
    .bus_read_accepted  (bus_read_accepted),
    .bus_read_done      (bus_read_done),
    .bus_read_data      (bus_read_data),
    .res                (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign core_ready           = out_res.core_ready;
  assign core_resp_valid      = out_res.core_resp_valid;
  assign core_resp_data       = out_res.core_resp_data;
  assign core_resp_tag        = out_res.core_resp_tag;
  assign core_resp_skip_check = out_res.core_resp_skip_check;
  assign bus_req_valid        = out_res.bus_req_valid;
  assign bus_req_is_write     = out_res.bus_req_is_write;
  assign bus_req_address      = out_res.bus_req_address;
  assign bus_req_size         = out_res.bus_req_size;
  assign bus_req_strobe       = out_res.bus_req_strobe;
  assign bus_req_write_data   = out_res.bus_req_write_data;
  assign bus_resp_ready       = out_res.bus_resp_ready;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted item produced no result");

  a_empty_takes_item: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("intake blocked with empty output register");

  a_stall_blocks_intake: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item taken while result stalled");

endmodule

`default_nettype wire
